### src/rpsi_pkg.sv
// types, code constants and power-of-ten tables for the register pair decoder
`default_nettype none
package rpsi_pkg;

  localparam logic [3:0] TYPE_U16      = 4'd0;
  localparam logic [3:0] TYPE_BITFIELD = 4'd1;
  localparam logic [3:0] TYPE_S16      = 4'd2;
  localparam logic [3:0] TYPE_U32_HI   = 4'd3;
  localparam logic [3:0] TYPE_U32_LO   = 4'd4;
  localparam logic [3:0] TYPE_S32_HI   = 4'd5;
  localparam logic [3:0] TYPE_S32_LO   = 4'd6;
  localparam logic [3:0] TYPE_F32_HI   = 4'd7;
  localparam logic [3:0] TYPE_F32_LO   = 4'd8;

  localparam int SCALE_LIMIT = 9;
  localparam int DIV_STEPS   = 3;
  localparam int DIV_STAGES  = 9;
  localparam int QUO_BITS    = DIV_STEPS * DIV_STAGES;
  localparam int STG_DEC     = 0;
  localparam int STG_MUL     = 1;
  localparam int STG_RND     = STG_MUL + DIV_STAGES + 1;
  localparam int STG_HALF    = STG_RND + 1;
  localparam int STG_SHIFT   = STG_HALF + 1;
  localparam int STG_OUT     = STG_SHIFT + 1;
  localparam int NUM_STG     = STG_OUT + 1;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_ZERO,
    KIND_SAT,
    KIND_FLT
  } kind_t;

  // 5^n shifted so that its top bit is bit 20
  localparam logic [20:0] DN_TAB [0:SCALE_LIMIT] = '{
    21'd1048576, 21'd1310720, 21'd1638400, 21'd2048000, 21'd1280000,
    21'd1600000, 21'd2000000, 21'd1250000, 21'd1562500, 21'd1953125
  };

  // exponent offsets of the 45-bit working significand
  localparam logic signed [9:0] MUL_XEXP [0:SCALE_LIMIT] = '{
    -10'sd43, -10'sd40, -10'sd37, -10'sd34, -10'sd30,
    -10'sd27, -10'sd24, -10'sd20, -10'sd17, -10'sd14
  };

  localparam logic signed [9:0] DIV_XEXP [0:SCALE_LIMIT] = '{
    -10'sd44, -10'sd47, -10'sd50, -10'sd53, -10'sd57,
    -10'sd60, -10'sd63, -10'sd67, -10'sd70, -10'sd73
  };

  typedef struct packed {
    kind_t                 kind;
    logic                  sign;
    logic [31:0]           ival;
    logic                  is_div;
    logic [3:0]            n;
    logic signed [9:0]     xexp;
    logic [23:0]           mant;
    logic [20:0]           dn;
    logic [20:0]           rem;
    logic [QUO_BITS-1:0]   qsh;
    logic [44:0]           prod;
    logic                  left;
    logic [2:0]            lsh;
    logic [4:0]            rsh;
    logic [24:0]           rval;
  } stage_t;

endpackage
`default_nettype wire

### src/register_pair_to_scaled_int.sv
// register pair decoder: integer and float32 words to a scaled int32
//
// channel  dir  ports
// in       in   in_valid, in_stall, in_decode_type, in_scale_pow10,
//               in_word_first, in_word_second
// out      out  out_valid, out_stall, out_scaled_value
//
// one transfer per cycle sustained while out_stall is low; the 27-bit
// restoring divider computes 3 quotient bits in each of 9 stages
// rst_n is synchronous and clears the valid bits of all stages
// a stage moves on when the stage after it is empty or moving, so bubbles
// close up under out_stall and in_stall rises only when every stage is full
`default_nettype none
module register_pair_to_scaled_int (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [3:0]         in_decode_type,
  input  wire logic signed [4:0]  in_scale_pow10,
  input  wire logic [15:0]        in_word_first,
  input  wire logic [15:0]        in_word_second,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] out_scaled_value
);

  localparam int NS = rpsi_pkg::NUM_STG;

  rpsi_pkg::stage_t st_r   [NS];
  rpsi_pkg::stage_t st_nxt [NS];
  logic [NS-1:0]    v_r;
  logic [NS-1:0]    free;

  // stage free when empty or its item moves on
  always_comb begin
    free[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      free[i] = !v_r[i] || free[i+1];
    end
  end

  assign in_stall         = !free[0];
  assign out_valid        = v_r[NS-1];
  assign out_scaled_value = st_r[NS-1].ival;

  // decode
  always_comb begin
    rpsi_pkg::stage_t d;
    logic [31:0]       bits;
    logic signed [4:0] sc;
    logic [4:0]        nabs;
    logic signed [9:0] e;
    d    = st_r[0];
    bits = '0;
    d.kind = rpsi_pkg::KIND_ZERO;
    d.sign = 1'b0;
    d.ival = '0;
    if (in_scale_pow10 > 5'sd9) begin
      sc = 5'sd9;
    end else if (in_scale_pow10 < -5'sd9) begin
      sc = -5'sd9;
    end else begin
      sc = in_scale_pow10;
    end
    nabs     = sc[4] ? 5'(-sc) : sc;
    d.n      = nabs[3:0];
    d.is_div = !sc[4] && (sc != 5'sd0);
    unique case (in_decode_type)
      rpsi_pkg::TYPE_U16, rpsi_pkg::TYPE_BITFIELD: begin
        d.kind = rpsi_pkg::KIND_INT;
        d.ival = {16'd0, in_word_first};
      end
      rpsi_pkg::TYPE_S16: begin
        d.kind = rpsi_pkg::KIND_INT;
        d.ival = {{16{in_word_first[15]}}, in_word_first};
      end
      rpsi_pkg::TYPE_U32_HI: begin
        d.kind = rpsi_pkg::KIND_INT;
        d.ival = in_word_first[15] ? 32'h7fff_ffff : {in_word_first, in_word_second};
      end
      rpsi_pkg::TYPE_U32_LO: begin
        d.kind = rpsi_pkg::KIND_INT;
        d.ival = in_word_second[15] ? 32'h7fff_ffff : {in_word_second, in_word_first};
      end
      rpsi_pkg::TYPE_S32_HI: begin
        d.kind = rpsi_pkg::KIND_INT;
        d.ival = {in_word_first, in_word_second};
      end
      rpsi_pkg::TYPE_S32_LO: begin
        d.kind = rpsi_pkg::KIND_INT;
        d.ival = {in_word_second, in_word_first};
      end
      rpsi_pkg::TYPE_F32_HI: bits = {in_word_first, in_word_second};
      rpsi_pkg::TYPE_F32_LO: bits = {in_word_second, in_word_first};
      default: d.kind = rpsi_pkg::KIND_ZERO;
    endcase
    e = $signed({2'b00, bits[30:23]}) - 10'sd127;
    d.mant = {1'b1, bits[22:0]};
    d.xexp = e + (d.is_div ? rpsi_pkg::DIV_XEXP[d.n] : rpsi_pkg::MUL_XEXP[d.n]);
    if (in_decode_type == rpsi_pkg::TYPE_F32_HI ||
        in_decode_type == rpsi_pkg::TYPE_F32_LO) begin
      d.sign = bits[31];
      if (bits[30:23] == 8'hff) begin
        d.kind = (bits[22:0] != 23'd0) ? rpsi_pkg::KIND_ZERO : rpsi_pkg::KIND_SAT;
      end else if (bits[30:23] == 8'h00) begin
        d.kind = rpsi_pkg::KIND_ZERO;
      end else begin
        d.kind = rpsi_pkg::KIND_FLT;
      end
    end
    st_nxt[rpsi_pkg::STG_DEC] = d;
  end

  // multiply and divider setup
  always_comb begin
    rpsi_pkg::stage_t d;
    d      = st_r[rpsi_pkg::STG_DEC];
    d.dn   = rpsi_pkg::DN_TAB[d.n];
    d.prod = 45'(d.mant) * 45'(d.dn);
    d.rem  = {1'b0, d.mant[23:4]};
    d.qsh  = {d.mant[3:0], 23'd0};
    st_nxt[rpsi_pkg::STG_MUL] = d;
  end

  // restoring divider stages
  for (genvar s = 0; s < rpsi_pkg::DIV_STAGES; s++) begin : g_div
    always_comb begin
      rpsi_pkg::stage_t d;
      logic [21:0]      r2;
      logic             ge;
      d = st_r[rpsi_pkg::STG_MUL + s];
      for (int j = 0; j < rpsi_pkg::DIV_STEPS; j++) begin
        r2 = {d.rem, d.qsh[rpsi_pkg::QUO_BITS-1]};
        ge = r2 >= {1'b0, d.dn};
        d.rem = ge ? 21'(r2 - {1'b0, d.dn}) : r2[20:0];
        d.qsh = {d.qsh[rpsi_pkg::QUO_BITS-2:0], ge};
      end
      st_nxt[rpsi_pkg::STG_MUL + 1 + s] = d;
    end
  end

  // round to single precision
  always_comb begin
    rpsi_pkg::stage_t d;
    logic [44:0]      x;
    logic             stk;
    logic [23:0]      m;
    logic             g;
    logic             st;
    logic [24:0]      r;
    logic signed [9:0] ex;
    d   = st_r[rpsi_pkg::STG_RND - 1];
    x   = d.is_div ? {d.qsh, 18'd0} : d.prod;
    stk = d.is_div && (d.rem != 21'd0);
    if (x[44]) begin
      m  = x[44:21];
      g  = x[20];
      st = (|x[19:0]) || stk;
      ex = d.xexp + 10'sd44;
    end else begin
      m  = x[43:20];
      g  = x[19];
      st = (|x[18:0]) || stk;
      ex = d.xexp + 10'sd43;
    end
    r = {1'b0, m} + {24'd0, g && (st || m[0])};
    if (r[24]) begin
      d.mant = r[24:1];
      d.xexp = ex + 10'sd1;
    end else begin
      d.mant = r[23:0];
      d.xexp = ex;
    end
    st_nxt[rpsi_pkg::STG_RND] = d;
  end

  // add one half in single precision
  always_comb begin
    rpsi_pkg::stage_t d;
    logic [4:0]       sh;
    logic [24:0]      t;
    d      = st_r[rpsi_pkg::STG_HALF - 1];
    d.left = 1'b0;
    d.lsh  = '0;
    d.rsh  = '0;
    d.rval = {1'b0, d.mant};
    sh     = 5'(10'sd22 - d.xexp);
    t      = {1'b0, d.mant} + (25'd1 << sh);
    if (d.kind == rpsi_pkg::KIND_FLT) begin
      if (d.xexp > 10'sd30) begin
        d.kind = rpsi_pkg::KIND_SAT;
      end else if (d.xexp < -10'sd2) begin
        d.kind = rpsi_pkg::KIND_ZERO;
      end
    end
    if (d.xexp > 10'sd23) begin
      d.left = 1'b1;
      d.lsh  = 3'(d.xexp - 10'sd23);
    end else if (d.xexp == 10'sd23) begin
      d.rval = {1'b0, d.mant} + {24'd0, d.mant[0]};
    end else if (t[24]) begin
      d.rval = {1'b0, t[24:1]} + {24'd0, t[0] && t[1]};
      d.rsh  = sh;
    end else begin
      d.rval = t;
      d.rsh  = sh + 5'd1;
    end
    st_nxt[rpsi_pkg::STG_HALF] = d;
  end

  // truncate toward zero
  always_comb begin
    rpsi_pkg::stage_t d;
    d = st_r[rpsi_pkg::STG_SHIFT - 1];
    if (d.kind == rpsi_pkg::KIND_FLT) begin
      d.ival = d.left ? ({8'd0, d.rval[23:0]} << d.lsh) : {7'd0, d.rval >> d.rsh};
    end
    st_nxt[rpsi_pkg::STG_SHIFT] = d;
  end

  // final select and sign
  always_comb begin
    rpsi_pkg::stage_t d;
    d = st_r[rpsi_pkg::STG_OUT - 1];
    case (d.kind)
      rpsi_pkg::KIND_INT:  d.ival = d.ival;
      rpsi_pkg::KIND_SAT:  d.ival = d.sign ? 32'h8000_0000 : 32'h7fff_ffff;
      rpsi_pkg::KIND_FLT:  d.ival = d.sign ? 32'(-d.ival) : d.ival;
      default:             d.ival = '0;
    endcase
    st_nxt[rpsi_pkg::STG_OUT] = d;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (free[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (free[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (free[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/register_pair_to_scaled_int_checker.sv
// port-level checks for the register pair decoder and their bind
`default_nettype none
module register_pair_to_scaled_int_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_scaled_value
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_scaled_value))
    else $error("out_scaled_value changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

endmodule

bind register_pair_to_scaled_int register_pair_to_scaled_int_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_scaled_value (out_scaled_value)
);
`default_nettype wire

### verif/register_pair_to_scaled_int_test.sv
// self-checking testbench for the register pair to scaled integer decoder
`timescale 1ns / 100ps
`default_nettype none
module register_pair_to_scaled_int_test;

  localparam int N_RANDOM = 2000;
  localparam int IDLE_LIMIT = 3000;
  localparam logic [31:0] INT_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] INT_MIN = 32'h80000000;

  typedef struct {
    logic [3:0]        dtype;
    logic signed [4:0] scale;
    logic [15:0]       w_first;
    logic [15:0]       w_second;
    bit                typed;
    logic [31:0]       value;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_decode_type = '0;
  logic signed [4:0] in_scale_pow10 = '0;
  logic [15:0] in_word_first = '0;
  logic [15:0] in_word_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_scaled_value;

  logic [31:0] expected_values[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int float_items = 0;
  int idle_cycles = 0;

  register_pair_to_scaled_int DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_decode_type(in_decode_type), .in_scale_pow10(in_scale_pow10),
    .in_word_first(in_word_first), .in_word_second(in_word_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_scaled_value(out_scaled_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int top_bit(input logic [127:0] v);
    int p;
    p = -1;
    for (int i = 0; i < 128; i++) if (v[i]) p = i;
    return p;
  endfunction

  // round to a 24-bit significand, nearest even; value = result * 2^sh
  function automatic logic [127:0] round_single(input logic [127:0] q, input logic sticky,
                                                output int sh);
    int p;
    logic [127:0] m, rem, half;
    p = top_bit(q);
    sh = 0;
    if (p <= 23) return q;
    sh = p - 23;
    m = q >> sh;
    rem = q & ((128'd1 << sh) - 1);
    half = 128'd1 << (sh - 1);
    if (rem > half || (rem == half && (sticky || m[0]))) m = m + 1;
    return m;
  endfunction

  function automatic logic [31:0] float_to_scaled(input logic [31:0] bits,
                                                  input logic signed [4:0] sc);
    int s, e, sh, fix;
    logic neg;
    logic [7:0] ex;
    logic [127:0] m, q, v, t;
    logic [63:0] div;
    logic sticky;
    logic [31:0] r;
    neg = bits[31];
    ex = bits[30:23];
    s = sc;
    if (s > rpsi_pkg::SCALE_LIMIT) s = rpsi_pkg::SCALE_LIMIT;
    if (s < -rpsi_pkg::SCALE_LIMIT) s = -rpsi_pkg::SCALE_LIMIT;
    if (ex == 8'hFF) begin
      if (bits[22:0] != 0) return 32'd0;
      return neg ? INT_MIN : INT_MAX;
    end
    if (ex == 0) begin
      m = bits[22:0];
      e = -149;
    end else begin
      m = {1'b1, bits[22:0]};
      e = int'(ex) - 150;
    end
    if (m == 0) return 32'd0;
    div = 1;
    for (int i = 0; i < (s < 0 ? -s : s); i++) div = div * 10;
    sticky = 1'b0;
    if (s > 0) begin
      q = (m << 60) / div;
      sticky = ((m << 60) % div) != 0;
      e = e - 60;
    end else begin
      q = m * div;
    end
    m = round_single(q, sticky, sh);
    e = e + sh;
    if (top_bit(m) + e >= 31) return neg ? INT_MIN : INT_MAX;
    fix = e + 60;
    if (fix < -127) v = '0;
    else if (fix < 0) v = m >> (-fix);
    else v = m << fix;
    t = v + (128'd1 << 59);
    t = round_single(t, 1'b0, sh);
    t = (t << sh) >> 60;
    r = t[31:0];
    return neg ? -r : r;
  endfunction

  function automatic logic [31:0] decode_pair(input logic [3:0] dtype,
                                              input logic signed [4:0] sc,
                                              input logic [15:0] wf, input logic [15:0] ws);
    logic [31:0] joined;
    case (dtype)
      rpsi_pkg::TYPE_U16, rpsi_pkg::TYPE_BITFIELD: return {16'd0, wf};
      rpsi_pkg::TYPE_S16: return {{16{wf[15]}}, wf};
      rpsi_pkg::TYPE_U32_HI: begin
        joined = {wf, ws};
        return joined[31] ? INT_MAX : joined;
      end
      rpsi_pkg::TYPE_U32_LO: begin
        joined = {ws, wf};
        return joined[31] ? INT_MAX : joined;
      end
      rpsi_pkg::TYPE_S32_HI: return {wf, ws};
      rpsi_pkg::TYPE_S32_LO: return {ws, wf};
      rpsi_pkg::TYPE_F32_HI: return float_to_scaled({wf, ws}, sc);
      rpsi_pkg::TYPE_F32_LO: return float_to_scaled({ws, wf}, sc);
      default: return 32'd0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_pair(input row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_decode_type <= row.dtype;
    in_scale_pow10 <= row.scale;
    in_word_first <= row.w_first;
    in_word_second <= row.w_second;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    expected_values.push_back(row.typed ? row.value :
                              decode_pair(row.dtype, row.scale, row.w_first, row.w_second));
    items_sent++;
    if (row.dtype == rpsi_pkg::TYPE_F32_HI || row.dtype == rpsi_pkg::TYPE_F32_LO)
      float_items++;
    @(posedge clk);
  endtask

  // result checking and idle watchdog
  always @(negedge clk) begin
    logic [31:0] want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: value %0d", out_scaled_value);
      end else begin
        want = expected_values.pop_front();
        if (want !== out_scaled_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d (%h) actual %0d (%h)",
                     $signed(want), want, out_scaled_value, out_scaled_value);
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls, with one long hold once 400 results have been seen
  initial begin
    int r;
    bit held;
    held = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= 400) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 100)) @(posedge clk);
      end else if (r < 65) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  row_t directed[] = '{
    '{rpsi_pkg::TYPE_U16,      5'sd0,  16'hFFFF, 16'h1234, 1, 32'd65535},
    '{rpsi_pkg::TYPE_U16,      5'sd0,  16'h0000, 16'hFFFF, 1, 32'd0},
    '{rpsi_pkg::TYPE_BITFIELD, 5'sd3,  16'hA5A5, 16'h0000, 1, 32'h0000A5A5},
    '{rpsi_pkg::TYPE_S16,      5'sd0,  16'h8000, 16'h0000, 1, 32'hFFFF8000},
    '{rpsi_pkg::TYPE_S16,      5'sd0,  16'h7FFF, 16'hFFFF, 1, 32'h00007FFF},
    '{rpsi_pkg::TYPE_U32_HI,   5'sd0,  16'hFFFF, 16'hFFFF, 1, INT_MAX},
    '{rpsi_pkg::TYPE_U32_HI,   5'sd0,  16'h7FFF, 16'hFFFF, 1, INT_MAX},
    '{rpsi_pkg::TYPE_U32_LO,   5'sd0,  16'h5678, 16'h1234, 1, 32'h12345678},
    '{rpsi_pkg::TYPE_U32_LO,   5'sd0,  16'h0000, 16'h8000, 1, INT_MAX},
    '{rpsi_pkg::TYPE_S32_HI,   5'sd0,  16'h8000, 16'h0000, 1, INT_MIN},
    '{rpsi_pkg::TYPE_S32_LO,   5'sd0,  16'hFFFF, 16'hFFFF, 1, 32'hFFFFFFFF},
    '{rpsi_pkg::TYPE_F32_HI,   5'sd0,  16'h7FC0, 16'h0000, 1, 32'd0},
    '{rpsi_pkg::TYPE_F32_HI,   -5'sd9, 16'h7F80, 16'h0000, 1, INT_MAX},
    '{rpsi_pkg::TYPE_F32_LO,   5'sd9,  16'h0000, 16'hFF80, 1, INT_MIN},
    '{rpsi_pkg::TYPE_F32_HI,   5'sd0,  16'h3FC0, 16'h0000, 1, 32'd2},
    '{rpsi_pkg::TYPE_F32_HI,   5'sd0,  16'hC020, 16'h0000, 1, 32'hFFFFFFFD},
    '{rpsi_pkg::TYPE_F32_LO,   5'sd0,  16'h0000, 16'h3F80, 1, 32'd1},
    '{4'd9,                    5'sd0,  16'hFFFF, 16'hFFFF, 1, 32'd0},
    '{4'd15,                   -5'sd1, 16'h1234, 16'h5678, 1, 32'd0},
    '{rpsi_pkg::TYPE_F32_HI,   5'sd0,  16'h3EFF, 16'hFFFF, 0, 32'd0},
    '{rpsi_pkg::TYPE_F32_HI,   5'sd15, 16'h4E6E, 16'h6B28, 0, 32'd0},
    '{rpsi_pkg::TYPE_F32_HI,   -5'sd16, 16'h4049, 16'h0FDB, 0, 32'd0},
    '{rpsi_pkg::TYPE_F32_LO,   5'sd2,  16'h0000, 16'h4F00, 0, 32'd0},
    '{rpsi_pkg::TYPE_F32_HI,   -5'sd4, 16'h0000, 16'h0001, 0, 32'd0},
    '{rpsi_pkg::TYPE_F32_HI,   -5'sd3, 16'hCB00, 16'h0001, 0, 32'd0}
  };

  initial begin
    row_t row;
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_pair(directed[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 1000) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_values.size() != 0) @(negedge clk);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      row.typed = 0;
      row.value = '0;
      row.dtype = r < 10 ? 4'($urandom_range(9, 15)) :
                  r < 45 ? 4'($urandom_range(0, 6)) :
                  (r < 72 ? rpsi_pkg::TYPE_F32_HI : rpsi_pkg::TYPE_F32_LO);
      row.scale = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31))
                                            : 5'(int'($urandom_range(0, 18)) - 9);
      row.w_first = $urandom_range(0, 65535);
      row.w_second = $urandom_range(0, 65535);
      // most floats get an exponent near the int32 range
      if (row.dtype inside {rpsi_pkg::TYPE_F32_HI, rpsi_pkg::TYPE_F32_LO} &&
          $urandom_range(0, 3) != 0) begin
        if (row.dtype == rpsi_pkg::TYPE_F32_HI)
          row.w_first = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 170)),
                         7'($urandom_range(0, 127))};
        else
          row.w_second = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 170)),
                          7'($urandom_range(0, 127))};
      end
      send_pair(row);
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_values.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d register pairs (%0d float), checked %0d results",
             items_sent, float_items, results_seen);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
